[design/dvsc_pkg.sv]
// ----------------------------------------------------------------------------
// Dotted version compare package
// Shared constants and types for the dotted version string comparator.
// ----------------------------------------------------------------------------
package dvsc_pkg;

  // Number of dot-separated parts kept for the installed string.
  localparam int MAX_PARTS = 8;
  // Width of one numeric part.
  localparam int PART_BITS = 32;

  // Index into the part store, and a count that can hold MAX_PARTS itself.
  localparam int PIDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int PCNT_W = $clog2(MAX_PARTS + 1);

  // Character width.
  localparam int CHAR_W = 8;

  // Comparison outcome, as seen on the result channel.
  typedef enum logic [1:0] {
    ORD_OLDER   = 2'd0,
    ORD_NEWER   = 2'd1,
    ORD_EQUAL   = 2'd2,
    ORD_UNKNOWN = 2'd3
  } order_t;

  // Long form of the optional prefix, matched in lower case.
  localparam logic [CHAR_W-1:0] VER_WORD [8] = '{
    8'h76, 8'h65, 8'h72, 8'h73, 8'h69, 8'h6f, 8'h6e, 8'h20
  };

endpackage

[design/dvsc_if.sv]
// ----------------------------------------------------------------------------
// Dotted version compare channels
// Valid/ready channels for the character requests and the compare results.
// ----------------------------------------------------------------------------

// Character request channel.
interface dvsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dvsc_pkg::CHAR_W-1:0]   ch;
  logic                          has_char;
  logic                          which_string;
  logic                          last;

  modport source (output valid, ch, has_char, which_string, last, input ready);
  modport sink   (input valid, ch, has_char, which_string, last, output ready);
endinterface

// Compare result channel.
interface dvsc_out_if;
  logic             valid;
  logic             ready;
  dvsc_pkg::order_t order;

  modport source (output valid, order, input ready);
  modport sink   (input valid, order, output ready);
endinterface

[design/dotted_version_string_compare.sv]
// ----------------------------------------------------------------------------
// Dotted version string comparator
// Parses an installed and a backup version string one character per request
// and reports whether the installed version is older, newer, equal or
// unknown.
// ----------------------------------------------------------------------------
// The block takes one character request per clock cycle, back to back. Each
// request is captured in an input register, and the parser state, the part
// store and the result register are updated from it when the result register
// is free or being emptied. The rate is set by the single parser step between
// the input register and the result register: one character per cycle. The
// block stops taking requests only while the input register is full and a
// finished result has not yet been taken. Parts of the installed string are
// kept in an eight-entry register store; entries are read only below the
// stored part count, so no clearing pass follows reset.

module dotted_version_string_compare (
  input  logic         clk,
  input  logic         rst_n,
  dvsc_in_if.sink      in_req,
  dvsc_out_if.source   out_res
);

  localparam int PB = dvsc_pkg::PART_BITS;
  localparam int CW = dvsc_pkg::CHAR_W;
  localparam int IW = dvsc_pkg::PIDX_W;
  localparam int NW = dvsc_pkg::PCNT_W;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_LEAD, PH_V1, PH_PREFIX, PH_MID, PH_V2, PH_NUM, PH_FAIL
  } phase_t;

  // Character classes.
  function automatic logic is_space(input logic [CW-1:0] c);
    is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [CW-1:0] c);
    is_digit = (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic [CW-1:0] to_lower(input logic [CW-1:0] c);
    to_lower = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  // Input register.
  logic          s1_valid_r;
  logic [CW-1:0] s1_ch_r;
  logic          s1_has_r;
  logic          s1_which_r;
  logic          s1_last_r;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  dvsc_pkg::order_t out_order_r, out_order_nxt;

  // Parser state.
  phase_t           phase_r, phase_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [PB-1:0]    acc_r, acc_nxt;
  logic             hasd_r, hasd_nxt;
  logic [NW-1:0]    pidx_r, pidx_nxt;
  logic             saw_r, saw_nxt;
  logic             sbad_r, sbad_nxt;
  dvsc_pkg::order_t verd_r, verd_nxt;
  logic             open_r, open_nxt;
  logic             owhich_r, owhich_nxt;

  // Installed string summary.
  logic [NW-1:0]    icount_r, icount_nxt;
  logic             ibad_r, ibad_nxt;
  logic             nz_has_r, nz_has_nxt;
  logic [IW-1:0]    nz_idx_r, nz_idx_nxt;
  logic             wnz_has_r, wnz_has_nxt;
  logic [IW-1:0]    wnz_idx_r, wnz_idx_nxt;

  // Part store.
  logic [PB-1:0]    parts_r [dvsc_pkg::MAX_PARTS];
  logic             wr_en;
  logic [IW-1:0]    wr_idx;
  logic [PB-1:0]    wr_data;

  // Step control.
  logic             advance;
  logic             step_en;
  logic             emit;
  logic             dot_close;
  logic             do_close;
  logic [PB+3:0]    acc_x10;
  logic             acc_ovf;
  logic [PB-1:0]    left_part;
  logic [CW-1:0]    lc;

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied.
  assign advance      = !out_valid_r || out_res.ready;
  assign step_en      = s1_valid_r && advance;
  assign in_req.ready = !s1_valid_r || advance;
  assign out_res.valid = out_valid_r;
  assign out_res.order = out_order_r;

  // Next decimal digit: acc * 10 + d, with overflow past the part width.
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {{PB{1'b0}}, s1_ch_r[3:0]};
  assign acc_ovf = |acc_x10[PB+3:PB];
  assign lc      = to_lower(s1_ch_r);

  // Parser step for one character request.
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    hasd_nxt      = hasd_r;
    pidx_nxt      = pidx_r;
    saw_nxt       = saw_r;
    sbad_nxt      = sbad_r;
    verd_nxt      = verd_r;
    open_nxt      = open_r;
    owhich_nxt    = owhich_r;
    icount_nxt    = icount_r;
    ibad_nxt      = ibad_r;
    nz_has_nxt    = nz_has_r;
    nz_idx_nxt    = nz_idx_r;
    wnz_has_nxt   = wnz_has_r;
    wnz_idx_nxt   = wnz_idx_r;
    wr_en         = 1'b0;
    wr_idx        = pidx_r[IW-1:0];
    wr_data       = acc_r;
    emit          = 1'b0;
    dot_close     = 1'b0;
    do_close      = 1'b0;
    left_part     = '0;
    out_order_nxt = out_order_r;

    if (step_en && (s1_has_r || s1_last_r)) begin
      // A request for the other string abandons the open one.
      if (open_r && (s1_which_r != owhich_r)) begin
        if (!owhich_r) begin
          ibad_nxt   = 1'b1;
          icount_nxt = '0;
        end
        open_nxt = 1'b0;
      end

      // Start a new string.
      if (!open_nxt) begin
        open_nxt    = 1'b1;
        owhich_nxt  = s1_which_r;
        phase_nxt   = PH_LEAD;
        pos_nxt     = 4'd0;
        acc_nxt     = '0;
        hasd_nxt    = 1'b0;
        pidx_nxt    = '0;
        saw_nxt     = 1'b0;
        sbad_nxt    = 1'b0;
        verd_nxt    = dvsc_pkg::ORD_EQUAL;
        wnz_has_nxt = 1'b0;
        wnz_idx_nxt = '0;
        if (!s1_which_r) begin
          icount_nxt = '0;
          ibad_nxt   = 1'b0;
          nz_has_nxt = 1'b0;
        end
      end

      // Character handling.
      if (s1_has_r) begin
        unique case (phase_nxt)
          PH_LEAD: begin
            if (is_space(s1_ch_r)) begin
              phase_nxt = PH_LEAD;
            end else if (lc == 8'h76) begin
              phase_nxt = PH_V1;
              pos_nxt   = 4'd1;
            end else if (is_digit(s1_ch_r)) begin
              phase_nxt = PH_NUM;
              acc_nxt   = PB'(s1_ch_r[3:0]);
              hasd_nxt  = 1'b1;
              saw_nxt   = 1'b0;
            end else begin
              sbad_nxt  = 1'b1;
              phase_nxt = PH_FAIL;
            end
          end
          PH_V1: begin
            if (lc == 8'h65) begin
              phase_nxt = PH_PREFIX;
              pos_nxt   = 4'd2;
            end else if (is_digit(s1_ch_r)) begin
              phase_nxt = PH_NUM;
              acc_nxt   = PB'(s1_ch_r[3:0]);
              hasd_nxt  = 1'b1;
              saw_nxt   = 1'b0;
            end else begin
              sbad_nxt  = 1'b1;
              phase_nxt = PH_FAIL;
            end
          end
          PH_PREFIX: begin
            // After "ver" the short and long forms part ways.
            if (pos_nxt == 4'd3) begin
              if (lc == 8'h73) begin
                pos_nxt = 4'd4;
              end else if (s1_ch_r == 8'h2e) begin
                pos_nxt = 4'd8;
              end else if (s1_ch_r == 8'h20) begin
                phase_nxt = PH_MID;
              end else begin
                sbad_nxt  = 1'b1;
                phase_nxt = PH_FAIL;
              end
            end else if (pos_nxt == 4'd8) begin
              if (s1_ch_r == 8'h20) begin
                phase_nxt = PH_MID;
              end else begin
                sbad_nxt  = 1'b1;
                phase_nxt = PH_FAIL;
              end
            end else if (pos_nxt < 4'd8 && lc == dvsc_pkg::VER_WORD[pos_nxt[2:0]]) begin
              if (pos_nxt == 4'd7) begin
                phase_nxt = PH_MID;
              end else begin
                pos_nxt = pos_nxt + 4'd1;
              end
            end else begin
              sbad_nxt  = 1'b1;
              phase_nxt = PH_FAIL;
            end
          end
          PH_MID: begin
            if (is_space(s1_ch_r)) begin
              phase_nxt = PH_MID;
            end else if (lc == 8'h76) begin
              phase_nxt = PH_V2;
            end else if (is_digit(s1_ch_r)) begin
              phase_nxt = PH_NUM;
              acc_nxt   = PB'(s1_ch_r[3:0]);
              hasd_nxt  = 1'b1;
              saw_nxt   = 1'b0;
            end else begin
              sbad_nxt  = 1'b1;
              phase_nxt = PH_FAIL;
            end
          end
          PH_V2: begin
            if (is_digit(s1_ch_r)) begin
              phase_nxt = PH_NUM;
              acc_nxt   = PB'(s1_ch_r[3:0]);
              hasd_nxt  = 1'b1;
              saw_nxt   = 1'b0;
            end else begin
              sbad_nxt  = 1'b1;
              phase_nxt = PH_FAIL;
            end
          end
          PH_NUM: begin
            if (is_digit(s1_ch_r)) begin
              if (saw_nxt || acc_ovf) begin
                sbad_nxt  = 1'b1;
                phase_nxt = PH_FAIL;
              end else begin
                acc_nxt  = acc_x10[PB-1:0];
                hasd_nxt = 1'b1;
              end
            end else if (s1_ch_r == 8'h2e) begin
              if (saw_nxt) begin
                sbad_nxt  = 1'b1;
                phase_nxt = PH_FAIL;
              end else begin
                dot_close = 1'b1;
              end
            end else if (is_space(s1_ch_r)) begin
              saw_nxt = 1'b1;
            end else begin
              sbad_nxt  = 1'b1;
              phase_nxt = PH_FAIL;
            end
          end
          default: begin
            phase_nxt = phase_nxt;
          end
        endcase
      end

      // Close a part on a dot, or on the end of a string inside a number.
      do_close = dot_close || (s1_last_r && phase_nxt == PH_NUM && !sbad_nxt);
      if (do_close) begin
        if (!hasd_nxt || pidx_nxt >= NW'(dvsc_pkg::MAX_PARTS)) begin
          sbad_nxt  = 1'b1;
          phase_nxt = PH_FAIL;
        end else begin
          if (!owhich_nxt) begin
            wr_en   = 1'b1;
            wr_idx  = pidx_nxt[IW-1:0];
            wr_data = acc_nxt;
            if (acc_nxt != '0) begin
              wnz_has_nxt = 1'b1;
              wnz_idx_nxt = pidx_nxt[IW-1:0];
            end
          end else if (verd_nxt == dvsc_pkg::ORD_EQUAL) begin
            // Stored installed part at this index; missing parts read as zero.
            if (pidx_nxt < icount_nxt) begin
              left_part = parts_r[pidx_nxt[IW-1:0]];
            end
            if (left_part < acc_nxt) begin
              verd_nxt = dvsc_pkg::ORD_OLDER;
            end else if (left_part > acc_nxt) begin
              verd_nxt = dvsc_pkg::ORD_NEWER;
            end
          end
          pidx_nxt = pidx_nxt + NW'(1);
          acc_nxt  = '0;
          hasd_nxt = 1'b0;
        end
      end

      // End of string: commit the installed summary or decide the result.
      if (s1_last_r) begin
        if (dot_close || !do_close) begin
          sbad_nxt  = 1'b1;
          phase_nxt = PH_FAIL;
        end
        open_nxt = 1'b0;
        if (!owhich_nxt) begin
          if (sbad_nxt) begin
            ibad_nxt   = 1'b1;
            icount_nxt = '0;
          end else begin
            icount_nxt = pidx_nxt;
            nz_has_nxt = wnz_has_nxt;
            nz_idx_nxt = wnz_idx_nxt;
          end
        end else begin
          emit = 1'b1;
          if (ibad_nxt || sbad_nxt) begin
            out_order_nxt = dvsc_pkg::ORD_UNKNOWN;
          end else if (verd_nxt != dvsc_pkg::ORD_EQUAL) begin
            out_order_nxt = verd_nxt;
          end else if (nz_has_nxt && pidx_nxt < icount_nxt
                       && pidx_nxt <= NW'(nz_idx_nxt)) begin
            out_order_nxt = dvsc_pkg::ORD_NEWER;
          end else begin
            out_order_nxt = dvsc_pkg::ORD_EQUAL;
          end
        end
      end
    end

    // Result register: load a new result, or drop one that was taken.
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_ch_r    <= in_req.ch;
      s1_has_r   <= in_req.has_char;
      s1_which_r <= in_req.which_string;
      s1_last_r  <= in_req.last;
    end
  end

  // Part store of the installed string.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      parts_r[wr_idx] <= wr_data;
    end
  end

  // Parser state, handshake state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_order_r <= dvsc_pkg::ORD_EQUAL;
      phase_r     <= PH_LEAD;
      pos_r       <= 4'd0;
      acc_r       <= '0;
      hasd_r      <= 1'b0;
      pidx_r      <= '0;
      saw_r       <= 1'b0;
      sbad_r      <= 1'b0;
      verd_r      <= dvsc_pkg::ORD_EQUAL;
      open_r      <= 1'b0;
      owhich_r    <= 1'b0;
      icount_r    <= '0;
      ibad_r      <= 1'b0;
      nz_has_r    <= 1'b0;
      nz_idx_r    <= '0;
      wnz_has_r   <= 1'b0;
      wnz_idx_r   <= '0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      out_order_r <= out_order_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      hasd_r      <= hasd_nxt;
      pidx_r      <= pidx_nxt;
      saw_r       <= saw_nxt;
      sbad_r      <= sbad_nxt;
      verd_r      <= verd_nxt;
      open_r      <= open_nxt;
      owhich_r    <= owhich_nxt;
      icount_r    <= icount_nxt;
      ibad_r      <= ibad_nxt;
      nz_has_r    <= nz_has_nxt;
      nz_idx_r    <= nz_idx_nxt;
      wnz_has_r   <= wnz_has_nxt;
      wnz_idx_r   <= wnz_idx_nxt;
    end
  end

  // A failed installed string leaves no stored parts to compare against.
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ibad_r |-> (icount_r == '0))
    else $error("installed string marked bad with a nonzero part count");

  // The last nonzero installed part lies below the stored part count.
  a_nz_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nz_has_r && !ibad_r) |-> (NW'(nz_idx_r) < icount_r))
    else $error("nonzero part index beyond the installed part count");

  // The part index and the installed part count never exceed the store depth.
  a_pidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pidx_r <= NW'(dvsc_pkg::MAX_PARTS)) && (icount_r <= NW'(dvsc_pkg::MAX_PARTS)))
    else $error("part index or count beyond the store depth");

  // A new result only follows the last character of a backup string.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_which_r && s1_last_r))
    else $error("result raised without a final backup character");

endmodule
